// ===== design/rtu_pkg.sv =====
// Package for the RTU frame receiver: sizes, codes, transaction types, CRC table.
package rtu_pkg;

  localparam int BUF_BYTES = 64;
  localparam int BUF_AW    = $clog2(BUF_BYTES);
  localparam int CNT_W     = $clog2(BUF_BYTES + 1);

  localparam logic [7:0]  GAP_RESET    = 8'd40;
  localparam logic [7:0]  TICK_MAX     = 8'hFF;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_RESIDUE  = 16'h0000;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam int          FUNC_EXC_BIT = 7;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_READ = 2'd2,
    CMD_TAKE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_ADDR = 2'd0,
    PH_FUNC = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } rtu_in_t;

  typedef struct packed {
    logic       frame_ready;
    logic [7:0] frame_address;
    logic [7:0] frame_function;
    logic [6:0] frame_length;
    logic [7:0] exception_code;
    logic [7:0] read_byte;
    phase_t     rx_phase;
  } rtu_out_t;

  typedef logic [15:0] crc_tab_t [256];

  // Byte-wide table for the reflected CRC-16/Modbus, built at elaboration.
  function automatic crc_tab_t crc_tab_gen();
    crc_tab_t    tab;
    logic [15:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 16'(i);
      for (int k = 0; k < 8; k++) begin
        if (c[0]) c = (c >> 1) ^ CRC_POLY;
        else      c = c >> 1;
      end
      tab[i] = c;
    end
    return tab;
  endfunction

  localparam crc_tab_t CRC_TAB = crc_tab_gen();

endpackage

// ===== design/rtu_frame_receiver.sv =====
// Modbus RTU frame receiver: byte/tick framing, CRC-16 check, data buffer in RAM.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in_     | input     | in_valid/in_ready   | rtu_in_t  (cmd, byte, index)
//  out_    | output    | out_valid/out_ready | rtu_out_t (frame status, data)
//  cfg_    | input     | cfg_wr_en           | cfg_wr_data = gap_ticks
//
// One transaction per cycle sustained while out_ready allows; each result appears in
// the cycle after its input is accepted, like the registered read of the 64-byte receive buffer RAM.
// in_ready = !out_valid || out_ready: the output register parts the two sides.
// Reset is synchronous (rst_n low) and clears all control state at once; the
// buffer RAM is not cleared, there is no clearing pass.
module rtu_frame_receiver
  import rtu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rtu_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output rtu_out_t   out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  // Frame state, updated at input acceptance; gap_r is written by cfg_wr_en
  logic [7:0]       gap_r;
  phase_t           phase_r,   phase_nxt;
  logic [15:0]      crc_r,     crc_nxt;
  logic [7:0]       addr_r,    addr_nxt;
  logic [7:0]       func_r,    func_nxt;
  logic [CNT_W-1:0] cnt_r,     cnt_nxt;
  logic             pend_r,    pend_nxt;
  logic             armed_r,   armed_nxt;
  logic [7:0]       tick_r,    tick_nxt;

  // Receive buffer RAM and its registered read
  logic [7:0]        rx_mem_r [BUF_BYTES];
  logic [7:0]        mem_q_r;
  logic              mem_we;
  logic [BUF_AW-1:0] mem_waddr;
  logic [BUF_AW-1:0] mem_raddr;

  // Output stage: snapshot of state after the transaction
  logic             out_valid_r;
  phase_t           s1_phase_r;
  logic [7:0]       s1_addr_r;
  logic [7:0]       s1_func_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic             s1_pend_r;
  logic             s1_rd_sel_r;
  logic             s1_err_clr_r;
  logic             s1_err_ld_r;
  // error_byte lives at the output side, since an exception take loads it
  // from the RAM read data
  logic [7:0]       err_r;

  logic             err_clr, err_ld, rd_sel;
  logic             in_acc, out_acc;
  logic             end_chk, take;
  logic [CNT_W-1:0] slot;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    addr_nxt  = addr_r;
    func_nxt  = func_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    armed_nxt = armed_r;
    tick_nxt  = tick_r;
    err_clr   = 1'b0;
    err_ld    = 1'b0;
    rd_sel    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    end_chk   = 1'b0;
    take      = 1'b0;
    slot      = '0;

    unique case (in_data.cmd)
      CMD_BYTE: begin
        if (!pend_r) begin
          unique case (phase_r)
            PH_ADDR: begin
              crc_nxt   = CRC_INIT;
              addr_nxt  = in_data.rx_byte;
              phase_nxt = PH_FUNC;
              cnt_nxt   = '0;
              err_clr   = 1'b1;
            end
            PH_FUNC: begin
              func_nxt  = in_data.rx_byte;
              phase_nxt = PH_DATA;
            end
            PH_DATA: begin
              // full buffer: keep overwriting the last slot
              slot      = (cnt_r >= CNT_W'(BUF_BYTES)) ? CNT_W'(BUF_BYTES - 1) : cnt_r;
              mem_we    = 1'b1;
              mem_waddr = BUF_AW'(slot);
              cnt_nxt   = slot + CNT_W'(1);
            end
            default: ; // unused code: CRC and timer only
          endcase
          armed_nxt = 1'b1;
          tick_nxt  = '0;
          crc_nxt   = {8'h00, crc_nxt[15:8]} ^ CRC_TAB[crc_nxt[7:0] ^ in_data.rx_byte];
        end
      end
      CMD_TICK: begin
        if (tick_r != TICK_MAX) tick_nxt = tick_r + 8'd1;
        end_chk = 1'b1;
      end
      CMD_READ: begin
        rd_sel    = 32'(in_data.read_index) < 32'(BUF_BYTES);
        mem_raddr = BUF_AW'(in_data.read_index);
      end
      CMD_TAKE: begin
        end_chk   = 1'b1;
        take      = 1'b1;
        mem_raddr = '0;
      end
      default: ;
    endcase

    // Frame end on silence; tick runs ahead of the check
    if (end_chk && armed_r && (tick_nxt > gap_r)) begin
      if ((phase_r == PH_DATA) && (crc_r == CRC_RESIDUE) && !pend_r) begin
        cnt_nxt  = (cnt_r >= CNT_W'(2)) ? cnt_r - CNT_W'(2) : '0;
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
      crc_nxt   = CRC_INIT;
      phase_nxt = PH_ADDR;
      armed_nxt = 1'b0;
      tick_nxt  = '0;
    end

    if (take && pend_nxt) begin
      if (func_r[FUNC_EXC_BIT]) begin
        err_ld  = 1'b1;
        cnt_nxt = CNT_W'(1);
      end
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GAP_RESET;
    end else if (cfg_wr_en) begin
      gap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR;
      crc_r   <= CRC_INIT;
      addr_r  <= '0;
      func_r  <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      armed_r <= 1'b0;
      tick_r  <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      addr_r  <= addr_nxt;
      func_r  <= func_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      armed_r <= armed_nxt;
      tick_r  <= tick_nxt;
    end
  end

  // Write and read never address the same transaction, so no forwarding:
  // a later read is issued at a later edge than the write.
  always_ff @(posedge clk) begin
    if (in_acc && mem_we) rx_mem_r[mem_waddr] <= in_data.rx_byte;
    if (in_acc)           mem_q_r <= rx_mem_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      err_r       <= '0;
    end else begin
      if (in_acc)       out_valid_r <= 1'b1;
      else if (out_acc) out_valid_r <= 1'b0;
      if (out_acc)      err_r <= out_data.exception_code;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_phase_r   <= phase_nxt;
      s1_addr_r    <= addr_nxt;
      s1_func_r    <= func_nxt;
      s1_cnt_r     <= cnt_nxt;
      s1_pend_r    <= pend_nxt;
      s1_rd_sel_r  <= rd_sel;
      s1_err_clr_r <= err_clr;
      s1_err_ld_r  <= err_ld;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_data.frame_ready    = s1_pend_r;
  assign out_data.frame_address  = s1_addr_r;
  assign out_data.frame_function = s1_func_r;
  assign out_data.frame_length   = 7'(s1_cnt_r);
  assign out_data.exception_code = s1_err_ld_r  ? mem_q_r :
                                   s1_err_clr_r ? 8'h00   : err_r;
  assign out_data.read_byte      = s1_rd_sel_r ? mem_q_r : 8'h00;
  assign out_data.rx_phase       = s1_phase_r;

endmodule

// ===== design/rtu_chk.sv =====
// Port-level checker for the RTU frame receiver, bound to the top level.
module rtu_chk
  import rtu_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input rtu_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // empty output stage always takes a transaction
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // a pending frame leaves the receiver waiting for an address byte
  a_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_ready |-> out_data.rx_phase == PH_ADDR)
    else $error("frame pending outside address phase");

  // an exception report comes with length one and no pending frame
  a_exc_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.exception_code != 8'h00)
      |-> (out_data.frame_length == 7'd1) && !out_data.frame_ready)
    else $error("exception report with bad length or pending frame");

endmodule

bind rtu_frame_receiver rtu_chk u_rtu_chk (.*);
